>>> rtl/sist_pkg.sv
// shared types and codes for the sorted integer set table
package sist_pkg;

    // width of the slot field of a request
    localparam int SLOT_W = 4;

    // width of a stored element
    localparam int DATA_W = 32;

    // request operation codes
    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_MEMBER = 3'd2,
        ACT_READ   = 3'd3,
        ACT_CLEAR  = 3'd4
    } t_action;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_SHIFT,
        S_PUT,
        S_RDWAIT,
        S_DONE
    } t_state;

    // outcome of one signed compare
    typedef struct packed {
        logic eq;
        logic gt;
    } t_cmp_res;

endpackage

>>> rtl/sist_cmp.sv
// shared signed compare unit used for every entry visited by a scan
module sist_cmp
    import sist_pkg::*;
(
    input  logic [DATA_W-1:0] i_entry,
    input  logic [DATA_W-1:0] i_key,
    output t_cmp_res          o_res
);

    // equality and signed greater-than of entry against key
    always_comb begin
        o_res.eq = (i_entry == i_key);
        o_res.gt = ($signed(i_entry) > $signed(i_key));
    end

endmodule

>>> rtl/sist_mem.sv
// element storage: one write port, one read port with registered data
module sist_mem
    import sist_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sorted_integer_set_table.sv
// sorted integer set table: top level with sequencer and result register
//
//  channel   direction  handshake            payload
//  request   in         i_valid / o_stall    i_action, i_value, i_slot
//  result    out        o_valid / i_stall    o_status, o_element, o_set_count
//
// One request at a time. A request is worked in
// one linear scan of the held entries through the single read port of the
// element memory, then for insert or remove one move pass over the entries
// behind the position, one entry per cycle. Read at index, clear and unused
// codes skip the scan. Reset is synchronous, active low, and empties
// the set. A stalled result waits in the output register while the next
// request is already worked on; the request side stalls until then.
module sorted_integer_set_table
    import sist_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [2:0]                          i_action,
    input  logic signed [DATA_W-1:0]            i_value,
    input  logic [SLOT_W-1:0]                   i_slot,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_status,
    output logic signed [DATA_W-1:0]            o_element,
    output logic [$clog2(CAPACITY+1)-1:0]       o_set_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // control registers
    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_dv, n_dv;
    logic              r_issue, n_issue;
    logic              r_o_valid;

    // payload registers
    t_action           r_action, n_action;
    logic [DATA_W-1:0] r_value, n_value;
    logic [SLOT_W-1:0] r_slot, n_slot;
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_elem, n_elem;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic [CW-1:0]     r_end, n_end;
    logic [CW-1:0]     r_cix, n_cix;
    logic [CW-1:0]     r_pos, n_pos;
    logic [AW-1:0]     r_wa, n_wa;
    t_status           r_o_status;
    logic [DATA_W-1:0] r_o_elem;
    logic [CW-1:0]     r_o_count;

    // memory port and compare unit
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [DATA_W-1:0] w_rdata;
    t_cmp_res          w_cmp;

    // scan and sequencing decisions
    logic              w_hit;
    logic              w_over;
    logic              w_more;
    logic              w_decide;
    logic [CW-1:0]     w_pos;
    logic              w_full;
    logic              w_pos_end;
    logic              w_rm_last;
    logic              w_in_range;
    logic              w_out_free;
    logic              w_load;
    logic [CW-1:0]     w_ptr_up;
    logic [CW-1:0]     w_ptr_dn;

    sist_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sist_cmp u_cmp (
        .i_entry (w_rdata),
        .i_key   (r_value),
        .o_res   (w_cmp)
    );

    // scan outcome: hit on equal, stop early once entries pass the key
    assign w_hit      = r_dv & w_cmp.eq;
    assign w_over     = r_dv & ~w_cmp.eq & w_cmp.gt;
    assign w_more     = (r_ptr < r_count);
    assign w_decide   = w_hit | w_over | (~r_dv & ~w_more);
    assign w_pos      = (w_hit | w_over) ? r_cix : r_count;
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_pos_end  = (w_pos == r_count);
    assign w_rm_last  = ((w_pos + CW'(1)) == r_count);
    assign w_in_range = (32'(r_slot) < 32'(r_count));
    assign w_ptr_up   = r_ptr + CW'(1);
    assign w_ptr_dn   = r_ptr - CW'(1);

    // result register hand-off
    assign w_out_free = ~r_o_valid | ~i_stall;
    assign w_load     = (r_state == S_DONE) & w_out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_START;
            end
            S_START: begin
                case (r_action) inside
                    ACT_INSERT, ACT_REMOVE, ACT_MEMBER: n_state = S_SCAN;
                    ACT_READ: n_state = w_in_range ? S_RDWAIT : S_DONE;
                    default:  n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (w_decide) begin
                    case (r_action)
                        ACT_INSERT: begin
                            if (w_hit || w_full) n_state = S_DONE;
                            else if (w_pos_end)  n_state = S_PUT;
                            else                 n_state = S_SHIFT;
                        end
                        ACT_REMOVE: begin
                            if (!w_hit || w_rm_last) n_state = S_DONE;
                            else                     n_state = S_SHIFT;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SHIFT: begin
                if (!r_issue) n_state = (r_action == ACT_INSERT) ? S_PUT : S_DONE;
            end
            S_PUT:    n_state = S_DONE;
            S_RDWAIT: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count  = r_count;
        n_dv     = r_dv;
        n_issue  = r_issue;
        n_action = r_action;
        n_value  = r_value;
        n_slot   = r_slot;
        n_status = r_status;
        n_elem   = r_elem;
        n_ptr    = r_ptr;
        n_end    = r_end;
        n_cix    = r_cix;
        n_pos    = r_pos;
        n_wa     = r_wa;
        w_we     = 1'b0;
        w_waddr  = r_wa;
        w_wdata  = w_rdata;
        w_raddr  = r_ptr[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_action = t_action'(i_action);
                    n_value  = i_value;
                    n_slot   = i_slot;
                    n_status = ST_OK;
                    n_elem   = '0;
                end
            end
            S_START: begin
                n_ptr   = '0;
                n_dv    = 1'b0;
                n_issue = 1'b0;
                case (r_action)
                    ACT_READ: begin
                        w_raddr = AW'(r_slot);
                        if (!w_in_range) n_status = ST_RANGE;
                    end
                    ACT_CLEAR: n_count = '0;
                    default: ;
                endcase
            end
            S_SCAN: begin
                if (w_decide) begin
                    n_dv  = 1'b0;
                    n_pos = w_pos;
                    case (r_action)
                        ACT_INSERT: begin
                            if (w_hit) begin
                                n_status = ST_MISS;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else if (!w_pos_end) begin
                                // move entries from the top down to the position
                                n_ptr   = r_count - CW'(1);
                                n_end   = w_pos;
                                n_issue = 1'b1;
                            end
                        end
                        ACT_REMOVE: begin
                            if (!w_hit) begin
                                n_status = ST_MISS;
                            end else if (w_rm_last) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                // move entries above the position down by one
                                n_ptr   = w_pos + CW'(1);
                                n_end   = r_count - CW'(1);
                                n_issue = 1'b1;
                            end
                        end
                        default: n_status = w_hit ? ST_OK : ST_MISS;
                    endcase
                end else if (w_more) begin
                    n_ptr = w_ptr_up;
                    n_cix = r_ptr;
                    n_dv  = 1'b1;
                end else begin
                    n_dv = 1'b0;
                end
            end
            S_SHIFT: begin
                // write back the entry read in the previous cycle
                if (r_dv) w_we = 1'b1;
                if (r_issue) begin
                    n_dv = 1'b1;
                    n_wa = (r_action == ACT_INSERT) ? w_ptr_up[AW-1:0] : w_ptr_dn[AW-1:0];
                    if (r_ptr == r_end) begin
                        n_issue = 1'b0;
                    end else begin
                        n_ptr = (r_action == ACT_INSERT) ? w_ptr_dn : w_ptr_up;
                    end
                end else begin
                    n_dv = 1'b0;
                    if (r_action == ACT_REMOVE) n_count = r_count - CW'(1);
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_pos[AW-1:0];
                w_wdata = r_value;
                n_count = r_count + CW'(1);
            end
            S_RDWAIT: begin
                n_elem = w_rdata;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_dv      <= 1'b0;
            r_issue   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_dv    <= n_dv;
            r_issue <= n_issue;
            if (w_load)        r_o_valid <= 1'b1;
            else if (!i_stall) r_o_valid <= 1'b0;
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_value  <= n_value;
        r_slot   <= n_slot;
        r_status <= n_status;
        r_elem   <= n_elem;
        r_ptr    <= n_ptr;
        r_end    <= n_end;
        r_cix    <= n_cix;
        r_pos    <= n_pos;
        r_wa     <= n_wa;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_status <= r_status;
            r_o_elem   <= r_elem;
            r_o_count  <= r_count;
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_element   = r_o_elem;
    assign o_set_count = r_o_count;

    // count never exceeds capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("set count above capacity");

    // memory writes only happen while moving entries or placing a new one
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_SHIFT || r_state == S_PUT))
        else $error("memory write outside move or place phase");

    // a nonzero element only comes with a successful read
    a_elem_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_element != '0) |-> (o_status == ST_OK))
        else $error("element returned with failing status");

    // count moves by one step or is cleared
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CW'(1) || r_count == $past(r_count) - CW'(1)
             || r_count == '0))
        else $error("count changed by more than one");

endmodule
